// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge out of reset.
`define MRRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MRRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MRRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mrrc_pkg.sv =====
`timescale 1ns / 1ps

package mrrc_pkg;

  localparam int BUFFER_DEPTH_DEF = 512;
  localparam int BYTE_W           = 8;
  localparam int OP_W             = 2;
  localparam int ERR_W            = 3;
  localparam int LEN_W            = 10;
  localparam int LEN_MAX          = 1023;
  localparam int MIN_FRAME        = 5;
  localparam int CFG_IDX_W        = 2;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CRC_W            = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [OP_W-1:0] OP_ARM   = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXP_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_FUNC = 2'd1;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_CRC       = 3'd3;
  localparam logic [ERR_W-1:0] ERR_ADDRESS   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_FUNCTION  = 3'd5;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_BYTE,
    CMD_CHECK
  } mrrc_cmd_kind_e;

  typedef struct packed {
    mrrc_cmd_kind_e      kind;
    logic [BYTE_W-1:0]   data;
  } mrrc_cmd_t;

  // Byte-wise Modbus CRC-16, reflected form.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/mrrc_channels.sv =====
`timescale 1ns / 1ps

interface mrrc_in_if import mrrc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface mrrc_out_if import mrrc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             frame_ok;
  logic [ERR_W-1:0] error_code;
  logic [LEN_W-1:0] frame_length;

  modport source (output valid, output frame_ok, output error_code, output frame_length,
                  input ready);
  modport sink   (input valid, input frame_ok, input error_code, input frame_length,
                  output ready);
endinterface

// ===== hdl/mrrc_front.sv =====
`timescale 1ns / 1ps

module mrrc_front import mrrc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  mrrc_in_if.sink        in_i,
  input  logic           fifo_full_i,
  output logic           push_o,
  output mrrc_cmd_t      push_cmd_o
);

  logic armed_q, armed_d;
  logic accept;

  assign in_i.ready = !fifo_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the transaction; drop bytes while disarmed and unused opcodes.
  always_comb begin
    armed_d         = armed_q;
    push_o          = 1'b0;
    push_cmd_o.kind = CMD_BYTE;
    push_cmd_o.data = in_i.rx_byte;
    if (accept) begin
      case (in_i.operation)
        OP_ARM: begin
          armed_d         = 1'b1;
          push_o          = 1'b1;
          push_cmd_o.kind = CMD_CLEAR;
        end
        OP_BYTE: begin
          push_o          = armed_q;
          push_cmd_o.kind = CMD_BYTE;
        end
        OP_CHECK: begin
          armed_d         = 1'b0;
          push_o          = 1'b1;
          push_cmd_o.kind = CMD_CHECK;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
    end
  end

endmodule

// ===== hdl/mrrc_fifo.sv =====
`timescale 1ns / 1ps

module mrrc_fifo import mrrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mrrc_cmd_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output mrrc_cmd_t pop_data_o,
  output logic      valid_o
);

`include "assert_macros.svh"

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  mrrc_cmd_t         entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `MRRC_ASSERT(a_fifo_no_overrun, !(push_i && full_o), "command pushed into full queue")
  `MRRC_ASSERT_IMP(a_fifo_ptrs, count_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with skewed pointers")

endmodule

// ===== hdl/mrrc_back.sv =====
`timescale 1ns / 1ps

module mrrc_back import mrrc_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  mrrc_cmd_t         cmd_i,
  output logic              cmd_pop_o,
  input  logic [BYTE_W-1:0] expected_address_i,
  input  logic [BYTE_W-1:0] expected_function_i,
  mrrc_out_if.source        out_o
);

`include "assert_macros.svh"

  localparam int CntW = $clog2(BUFFER_DEPTH + 1);

  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [BYTE_W-1:0] recent_q [2];
  logic [BYTE_W-1:0] recent_d [2];
  logic [BYTE_W-1:0] hdr_q [2];
  logic [BYTE_W-1:0] hdr_d [2];
  logic [CntW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q, out_valid_d;
  logic              frame_ok_q;
  logic [ERR_W-1:0]  err_q;
  logic [LEN_W-1:0]  len_q;

  logic              is_check;
  logic [ERR_W-1:0]  err;
  logic [LEN_W-1:0]  len;

  assign is_check  = (cmd_i.kind == CMD_CHECK);
  // Hold a check while the previous verdict still waits to be taken.
  assign cmd_pop_o = cmd_valid_i && (!is_check || !out_valid_q || out_o.ready);

  always_comb begin
    if (32'(count_q) < MIN_FRAME) begin
      err = ERR_SHORT;
    end else if (ovf_q) begin
      err = ERR_OVERFLOW;
    end else if (recent_q[0] != crc_q[7:0] || recent_q[1] != crc_q[15:8]) begin
      err = ERR_CRC;
    end else if (hdr_q[0] != expected_address_i) begin
      err = ERR_ADDRESS;
    end else if (hdr_q[1] != expected_function_i) begin
      err = ERR_FUNCTION;
    end else begin
      err = ERR_NONE;
    end
    if (32'(count_q) > LEN_MAX) begin
      len = LEN_W'(LEN_MAX);
    end else begin
      len = LEN_W'(count_q);
    end
  end

  always_comb begin
    crc_d    = crc_q;
    recent_d = recent_q;
    hdr_d    = hdr_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        CMD_CLEAR: begin
          crc_d    = CRC_INIT;
          recent_d = '{default: '0};
          hdr_d    = '{default: '0};
          count_d  = '0;
          ovf_d    = 1'b0;
        end
        CMD_BYTE: begin
          if (count_q == CntW'(BUFFER_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            if (count_q < CntW'(2)) begin
              hdr_d[count_q[0]] = cmd_i.data;
            end else begin
              // Feed the byte leaving the delay line; the trailing CRC stays out.
              crc_d = crc_feed(crc_q, recent_q[0]);
            end
            recent_d[0] = recent_q[1];
            recent_d[1] = cmd_i.data;
            count_d     = count_q + 1'b1;
          end
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_pop_o && is_check) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      recent_q    <= '{default: '0};
      hdr_q       <= '{default: '0};
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      recent_q    <= recent_d;
      hdr_q       <= hdr_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && is_check) begin
      frame_ok_q <= (err == ERR_NONE);
      err_q      <= err;
      len_q      <= len;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_ok     = frame_ok_q;
  assign out_o.error_code   = err_q;
  assign out_o.frame_length = len_q;

  `MRRC_ASSERT(a_cnt_bound, count_q <= CntW'(BUFFER_DEPTH), "byte count beyond buffer depth")
  `MRRC_ASSERT_IMP(a_ovf_full, ovf_q, count_q == CntW'(BUFFER_DEPTH), "overflow below depth")
  `MRRC_ASSERT_NXT(a_check_out, cmd_pop_o && is_check, out_valid_q, "check gave no verdict")

endmodule

// ===== hdl/modbus_rtu_response_checker_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Interface    Payload
// in_i      in   mrrc_in_if   operation[1:0], rx_byte[7:0]
// out_o     out  mrrc_out_if  frame_ok, error_code[2:0], frame_length[9:0]
// cfg_*     in   plain write  cfg_index_i[1:0], cfg_data_i[7:0]
//
// One input transaction per cycle unless the queue is full; the back end runs the CRC.
// A check verdict passes the queue entry, then the back end's verdict register.
// A two-entry command queue lets the front keep taking items while a verdict is stalled.
// Only a check waiting on a full output register stalls the back end.
// Reset is asynchronous; all frame state and the queue are cleared at once.

module modbus_rtu_response_checker_core import mrrc_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mrrc_in_if.sink              in_i,
  mrrc_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  logic [BYTE_W-1:0] exp_addr_q;
  logic [BYTE_W-1:0] exp_func_q;

  logic      push, fifo_full, cmd_valid, cmd_pop;
  mrrc_cmd_t push_cmd, cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= 8'd1;
      exp_func_q <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EXP_ADDR: exp_addr_q <= cfg_data_i;
        CFG_EXP_FUNC: exp_func_q <= cfg_data_i;
        default: begin
          exp_addr_q <= exp_addr_q;
        end
      endcase
    end
  end

  mrrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  mrrc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd),
    .valid_o     (cmd_valid)
  );

  mrrc_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_valid_i         (cmd_valid),
    .cmd_i               (cmd),
    .cmd_pop_o           (cmd_pop),
    .expected_address_i  (exp_addr_q),
    .expected_function_i (exp_func_q),
    .out_o               (out_o)
  );

endmodule
